// ----- rtl/rfci_pkg.sv -----
// Shared types, constants and fixed-point helpers for the finite cylinder intersector.
`default_nettype none
package rfci_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QW = 32;
	localparam int QDEPTH = 4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NEG = 2'd1;
	localparam logic [1:0] ST_K1Z = 2'd2;

	localparam logic [1:0] REG_CAM_X = 2'd0;
	localparam logic [1:0] REG_CAM_Y = 2'd1;
	localparam logic [1:0] REG_CAM_Z = 2'd2;

	localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
	localparam logic signed [63:0] QMIN64 = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic signed [17:0] nz;
		logic [14:0] len;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		logic signed [31:0] disc;
	} job_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > QMAX64) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < QMIN64) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] s;
		s = 64'(a) + 64'(b);
		return sat64(s);
	endfunction

	function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] s;
		s = 64'(a) - 64'(b);
		return sat64(s);
	endfunction

	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b, input int frac);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat64(p >>> frac);
	endfunction

	function automatic logic signed [31:0] sx18(input logic signed [17:0] v);
		return {{14{v[17]}}, v};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rfci_front.sv -----
// Front pipeline: forms the quadratic coefficients and the discriminant of each beat.
`default_nettype none
module rfci_front #(
	parameter int FRAC_BITS = rfci_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_fire,
	input wire rfci_pkg::geo_t geo_in,
	input wire logic [30:0] radius,
	input wire logic signed [31:0] cam_x,
	input wire logic signed [31:0] cam_y,
	input wire logic signed [31:0] cam_z,
	output logic push,
	output rfci_pkg::job_t job
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	rfci_pkg::geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7;
	logic signed [31:0] rad_s1;
	logic signed [31:0] oc_s1 [3];
	logic signed [31:0] dd_s2 [3];
	logic signed [31:0] dn_s2 [3];
	logic signed [31:0] on_s2 [3];
	logic signed [31:0] doc_s2 [3];
	logic signed [31:0] oo_s2 [3];
	logic signed [31:0] rr_s2, rr_s3, rr_s4;
	logic signed [31:0] dd_s3, dn_s3, on_s3, doc_s3, oo_s3;
	logic signed [31:0] dd_s4, doc_s4, oo_s4, dndn_s4, dnon_s4, onon_s4;
	logic signed [31:0] k1_s5, k2_s5, k3_s5;
	logic signed [31:0] k1_s6, k2_s6, k2sq_s6, k1k3_s6;
	logic signed [31:0] k1_s7, k2_s7, disc_s7;
	logic signed [31:0] d_c [3];
	logic signed [31:0] n_c [3];

	always_comb begin
		d_c[0] = geo_s1.dx;
		d_c[1] = geo_s1.dy;
		d_c[2] = geo_s1.dz;
		n_c[0] = rfci_pkg::sx18(geo_s1.nx);
		n_c[1] = rfci_pkg::sx18(geo_s1.ny);
		n_c[2] = rfci_pkg::sx18(geo_s1.nz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1 <= geo_in;
			rad_s1 <= $signed({1'b0, radius});
			oc_s1[0] <= rfci_pkg::ssub(cam_x, geo_in.bx);
			oc_s1[1] <= rfci_pkg::ssub(cam_y, geo_in.by);
			oc_s1[2] <= rfci_pkg::ssub(cam_z, geo_in.bz);

			geo_s2 <= geo_s1;
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= rfci_pkg::qmul(d_c[i], d_c[i], FRAC_BITS);
				dn_s2[i] <= rfci_pkg::qmul(d_c[i], n_c[i], FRAC_BITS);
				on_s2[i] <= rfci_pkg::qmul(oc_s1[i], n_c[i], FRAC_BITS);
				doc_s2[i] <= rfci_pkg::qmul(d_c[i], oc_s1[i], FRAC_BITS);
				oo_s2[i] <= rfci_pkg::qmul(oc_s1[i], oc_s1[i], FRAC_BITS);
			end
			rr_s2 <= rfci_pkg::qmul(rad_s1, rad_s1, FRAC_BITS);

			geo_s3 <= geo_s2;
			dd_s3 <= rfci_pkg::sadd(rfci_pkg::sadd(dd_s2[0], dd_s2[1]), dd_s2[2]);
			dn_s3 <= rfci_pkg::sadd(rfci_pkg::sadd(dn_s2[0], dn_s2[1]), dn_s2[2]);
			on_s3 <= rfci_pkg::sadd(rfci_pkg::sadd(on_s2[0], on_s2[1]), on_s2[2]);
			doc_s3 <= rfci_pkg::sadd(rfci_pkg::sadd(doc_s2[0], doc_s2[1]), doc_s2[2]);
			oo_s3 <= rfci_pkg::sadd(rfci_pkg::sadd(oo_s2[0], oo_s2[1]), oo_s2[2]);
			rr_s3 <= rr_s2;

			geo_s4 <= geo_s3;
			dd_s4 <= dd_s3;
			doc_s4 <= doc_s3;
			oo_s4 <= oo_s3;
			rr_s4 <= rr_s3;
			dndn_s4 <= rfci_pkg::qmul(dn_s3, dn_s3, FRAC_BITS);
			dnon_s4 <= rfci_pkg::qmul(dn_s3, on_s3, FRAC_BITS);
			onon_s4 <= rfci_pkg::qmul(on_s3, on_s3, FRAC_BITS);

			geo_s5 <= geo_s4;
			k1_s5 <= rfci_pkg::ssub(dd_s4, dndn_s4);
			k2_s5 <= rfci_pkg::sat64(64'(rfci_pkg::ssub(doc_s4, dnon_s4)) <<< 1);
			k3_s5 <= rfci_pkg::ssub(rfci_pkg::ssub(oo_s4, onon_s4), rr_s4);

			geo_s6 <= geo_s5;
			k1_s6 <= k1_s5;
			k2_s6 <= k2_s5;
			k2sq_s6 <= rfci_pkg::qmul(k2_s5, k2_s5, FRAC_BITS);
			k1k3_s6 <= rfci_pkg::qmul(k1_s5, k3_s5, FRAC_BITS);

			geo_s7 <= geo_s6;
			k1_s7 <= k1_s6;
			k2_s7 <= k2_s6;
			disc_s7 <= rfci_pkg::ssub(k2sq_s6, rfci_pkg::sat64(64'(k1k3_s6) <<< 2));
		end
	end

	assign push = en && v_s7;
	assign job.geo = geo_s7;
	assign job.k1 = k1_s7;
	assign job.k2 = k2_s7;
	assign job.disc = disc_s7;

endmodule
`default_nettype wire

// ----- rtl/rfci_queue.sv -----
// Short queue of coefficient sets between the front and back pipelines.
`default_nettype none
module rfci_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rfci_pkg::job_t wdata,
	input wire logic pop,
	output rfci_pkg::job_t rdata,
	output logic full,
	output logic empty
);

	localparam int AW = $clog2(rfci_pkg::QDEPTH);

	rfci_pkg::job_t mem_q [rfci_pkg::QDEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full = (count_q == (AW+1)'(rfci_pkg::QDEPTH));
	assign empty = (count_q == '0);

endmodule
`default_nettype wire

// ----- rtl/rfci_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rfci_isqrt #(
	parameter int FRAC_BITS = rfci_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [((32 + FRAC_BITS + 1) / 2) * 2 - 1:0] rad,
	output logic [(32 + FRAC_BITS + 1) / 2 - 1:0] root
);

	localparam int RW = ((32 + FRAC_BITS + 1) / 2) * 2;
	localparam int NR = RW / 2;
	localparam int RM = NR + 3;

	logic [RM-1:0] rem_q [NR];
	logic [NR-1:0] root_q [NR];
	logic [RW-1:0] rest_q [NR];
	logic [RM-1:0] rem_n [NR];
	logic [NR-1:0] root_n [NR];
	logic [RW-1:0] rest_n [NR];

	always_comb begin
		logic [RM-1:0] ri, r2, trial;
		logic [NR-1:0] oi;
		logic [RW-1:0] si;
		for (int i = 0; i < NR; i++) begin
			if (i == 0) begin
				ri = '0;
				oi = '0;
				si = rad;
			end else begin
				ri = rem_q[i-1];
				oi = root_q[i-1];
				si = rest_q[i-1];
			end
			r2 = {ri[RM-3:0], si[RW-1:RW-2]};
			trial = RM'({oi, 2'b01});
			if (r2 >= trial) begin
				rem_n[i] = r2 - trial;
				root_n[i] = {oi[NR-2:0], 1'b1};
			end else begin
				rem_n[i] = r2;
				root_n[i] = {oi[NR-2:0], 1'b0};
			end
			rest_n[i] = {si[RW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NR; i++) begin
				rem_q[i] <= rem_n[i];
				root_q[i] <= root_n[i];
				rest_q[i] <= rest_n[i];
			end
		end
	end

	assign root = root_q[NR-1];

endmodule
`default_nettype wire

// ----- rtl/rfci_div.sv -----
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
`default_nettype none
module rfci_div #(
	parameter int FRAC_BITS = rfci_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [33:0] num,
	input wire logic signed [32:0] den,
	output logic signed [31:0] quo
);

	localparam int NW = 34 + FRAC_BITS;
	localparam int DS = rfci_pkg::QW;

	logic [32:0] rem_q [DS];
	logic [31:0] low_q [DS];
	logic [31:0] quo_q [DS];
	logic [32:0] dv_q [DS];
	logic neg_q [DS];
	logic ovf_q [DS];
	logic [32:0] rem_n [DS];
	logic [31:0] low_n [DS];
	logic [31:0] quo_n [DS];

	logic [33:0] mag_n;
	logic [32:0] mag_d;
	logic [NW-1:0] dividend;
	logic [32:0] rem0;
	logic neg0, ovf0;

	always_comb begin
		mag_n = num[33] ? 34'(-num) : 34'(num);
		mag_d = den[32] ? 33'(-den) : 33'(den);
		dividend = NW'(mag_n) << FRAC_BITS;
		rem0 = 33'(dividend[NW-1:32]);
		ovf0 = (rem0 >= mag_d);
		neg0 = num[33] ^ den[32];
	end

	always_comb begin
		logic [32:0] ri, di;
		logic [31:0] li, qi;
		logic [33:0] t;
		for (int i = 0; i < DS; i++) begin
			if (i == 0) begin
				ri = rem0;
				li = dividend[31:0];
				qi = '0;
				di = mag_d;
			end else begin
				ri = rem_q[i-1];
				li = low_q[i-1];
				qi = quo_q[i-1];
				di = dv_q[i-1];
			end
			t = {ri, li[31]};
			if (t >= {1'b0, di}) begin
				rem_n[i] = 33'(t - {1'b0, di});
				quo_n[i] = {qi[30:0], 1'b1};
			end else begin
				rem_n[i] = t[32:0];
				quo_n[i] = {qi[30:0], 1'b0};
			end
			low_n[i] = {li[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DS; i++) begin
				rem_q[i] <= rem_n[i];
				low_q[i] <= low_n[i];
				quo_q[i] <= quo_n[i];
				if (i == 0) begin
					dv_q[i] <= mag_d;
					neg_q[i] <= neg0;
					ovf_q[i] <= ovf0;
				end else begin
					dv_q[i] <= dv_q[i-1];
					neg_q[i] <= neg_q[i-1];
					ovf_q[i] <= ovf_q[i-1];
				end
			end
		end
	end

	always_comb begin
		if (ovf_q[DS-1] || quo_q[DS-1][31]) begin
			quo = neg_q[DS-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			quo = neg_q[DS-1] ? -$signed(quo_q[DS-1]) : $signed(quo_q[DS-1]);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rfci_back.sv -----
// Back pipeline: square root, two divisions, axial clipping and the result register.
`default_nettype none
module rfci_back #(
	parameter int FRAC_BITS = rfci_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire rfci_pkg::job_t job,
	output logic pop,
	input wire logic signed [31:0] cam_x,
	input wire logic signed [31:0] cam_y,
	input wire logic signed [31:0] cam_z,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] t_plus,
	output logic signed [31:0] t_minus,
	output logic plus_clipped,
	output logic minus_clipped,
	output logic [1:0] status
);

	localparam int RW = ((32 + FRAC_BITS + 1) / 2) * 2;
	localparam int NR = RW / 2;
	localparam int DS = rfci_pkg::QW;

	typedef struct packed {
		logic [1:0] st;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		rfci_pkg::geo_t geo;
	} sb_t;

	logic en;
	sb_t sb_in;
	logic [RW-1:0] rad;
	logic [NR-1:0] root;

	logic [NR-1:0] v_sq_q;
	sb_t sb_sq_q [NR];
	logic [DS-1:0] v_dv_q;
	sb_t sb_dv_q [DS];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	sb_t sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic signed [33:0] num_p_s1, num_m_s1;
	logic signed [32:0] den_s1;
	logic signed [31:0] qp, qm;
	logic signed [31:0] tp_s2, tm_s2, tp_s3, tm_s3, tp_s4, tm_s4, tp_s5, tm_s5;
	logic signed [31:0] pp_s3 [3];
	logic signed [31:0] pm_s3 [3];
	logic signed [31:0] ep_s4 [3];
	logic signed [31:0] em_s4 [3];
	logic signed [31:0] mp_s5 [3];
	logic signed [31:0] mm_s5 [3];

	logic signed [31:0] d_c [3];
	logic signed [31:0] b_c [3];
	logic signed [31:0] c_c [3];
	logic signed [31:0] n_c [3];
	logic signed [33:0] nk2, s_ext;
	logic signed [31:0] m_p, m_m;
	logic signed [47:0] lenq;
	logic out_p, out_m;

	logic out_valid_q;
	logic signed [31:0] t_plus_q, t_minus_q;
	logic plus_clipped_q, minus_clipped_q;
	logic [1:0] status_q;

	assign en = !out_valid_q || out_ready;
	assign pop = en && job_valid;

	always_comb begin
		sb_in.k1 = job.k1;
		sb_in.k2 = job.k2;
		sb_in.geo = job.geo;
		if (job.disc[31]) begin
			sb_in.st = rfci_pkg::ST_NEG;
		end else if (job.k1 == '0) begin
			sb_in.st = rfci_pkg::ST_K1Z;
		end else begin
			sb_in.st = rfci_pkg::ST_OK;
		end
		rad = job.disc[31] ? '0 : (RW'(job.disc[30:0]) << FRAC_BITS);
	end

	rfci_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
		.clk (clk),
		.en  (en),
		.rad (rad),
		.root(root)
	);

	always_comb begin
		nk2 = -(34'(sb_sq_q[NR-1].k2));
		s_ext = $signed(34'(root));
	end

	rfci_div #(.FRAC_BITS(FRAC_BITS)) u_div_p (
		.clk(clk),
		.en (en),
		.num(num_p_s1),
		.den(den_s1),
		.quo(qp)
	);

	rfci_div #(.FRAC_BITS(FRAC_BITS)) u_div_m (
		.clk(clk),
		.en (en),
		.num(num_m_s1),
		.den(den_s1),
		.quo(qm)
	);

	always_comb begin
		d_c[0] = sb_s2.geo.dx;
		d_c[1] = sb_s2.geo.dy;
		d_c[2] = sb_s2.geo.dz;
		b_c[0] = sb_s3.geo.bx;
		b_c[1] = sb_s3.geo.by;
		b_c[2] = sb_s3.geo.bz;
		c_c[0] = cam_x;
		c_c[1] = cam_y;
		c_c[2] = cam_z;
		n_c[0] = rfci_pkg::sx18(sb_s4.geo.nx);
		n_c[1] = rfci_pkg::sx18(sb_s4.geo.ny);
		n_c[2] = rfci_pkg::sx18(sb_s4.geo.nz);
		m_p = rfci_pkg::sadd(rfci_pkg::sadd(mp_s5[0], mp_s5[1]), mp_s5[2]);
		m_m = rfci_pkg::sadd(rfci_pkg::sadd(mm_s5[0], mm_s5[1]), mm_s5[2]);
		lenq = $signed(48'(sb_s5.geo.len) << FRAC_BITS);
		out_p = (m_p <= 32'sd0) || (48'(m_p) >= lenq);
		out_m = (m_m <= 32'sd0) || (48'(m_m) >= lenq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq_q <= '0;
			v_dv_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_sq_q <= {v_sq_q[NR-2:0], job_valid};
			v_s1 <= v_sq_q[NR-1];
			v_dv_q <= {v_dv_q[DS-2:0], v_s1};
			v_s2 <= v_dv_q[DS-1];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sq_q[0] <= sb_in;
			for (int i = 1; i < NR; i++) begin
				sb_sq_q[i] <= sb_sq_q[i-1];
			end

			sb_s1 <= sb_sq_q[NR-1];
			num_p_s1 <= nk2 + s_ext;
			num_m_s1 <= nk2 - s_ext;
			den_s1 <= {sb_sq_q[NR-1].k1, 1'b0};

			sb_dv_q[0] <= sb_s1;
			for (int i = 1; i < DS; i++) begin
				sb_dv_q[i] <= sb_dv_q[i-1];
			end

			sb_s2 <= sb_dv_q[DS-1];
			if (sb_dv_q[DS-1].st == rfci_pkg::ST_OK) begin
				tp_s2 <= qp;
				tm_s2 <= qm;
			end else begin
				tp_s2 <= '0;
				tm_s2 <= '0;
			end

			sb_s3 <= sb_s2;
			tp_s3 <= tp_s2;
			tm_s3 <= tm_s2;
			for (int i = 0; i < 3; i++) begin
				pp_s3[i] <= rfci_pkg::qmul(tp_s2, d_c[i], FRAC_BITS);
				pm_s3[i] <= rfci_pkg::qmul(tm_s2, d_c[i], FRAC_BITS);
			end

			sb_s4 <= sb_s3;
			tp_s4 <= tp_s3;
			tm_s4 <= tm_s3;
			for (int i = 0; i < 3; i++) begin
				ep_s4[i] <= rfci_pkg::ssub(rfci_pkg::sadd(c_c[i], pp_s3[i]), b_c[i]);
				em_s4[i] <= rfci_pkg::ssub(rfci_pkg::sadd(c_c[i], pm_s3[i]), b_c[i]);
			end

			sb_s5 <= sb_s4;
			tp_s5 <= tp_s4;
			tm_s5 <= tm_s4;
			for (int i = 0; i < 3; i++) begin
				mp_s5[i] <= rfci_pkg::qmul(ep_s4[i], n_c[i], FRAC_BITS);
				mm_s5[i] <= rfci_pkg::qmul(em_s4[i], n_c[i], FRAC_BITS);
			end

			status_q <= sb_s5.st;
			if (sb_s5.st == rfci_pkg::ST_OK && out_p) begin
				t_plus_q <= -(32'sd1 <<< FRAC_BITS);
				plus_clipped_q <= 1'b1;
			end else begin
				t_plus_q <= tp_s5;
				plus_clipped_q <= 1'b0;
			end
			if (sb_s5.st == rfci_pkg::ST_OK && out_m) begin
				t_minus_q <= -(32'sd1 <<< FRAC_BITS);
				minus_clipped_q <= 1'b1;
			end else begin
				t_minus_q <= tm_s5;
				minus_clipped_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign t_plus = t_plus_q;
	assign t_minus = t_minus_q;
	assign plus_clipped = plus_clipped_q;
	assign minus_clipped = minus_clipped_q;
	assign status = status_q;

endmodule
`default_nettype wire

// ----- rtl/ray_finite_cylinder_intersect.sv -----
// Top level of the finite cylinder intersector with its camera registers.
`default_nettype none
// Each input beat carries one ray direction and one finite cylinder; the ray starts at the
// camera origin held in three APB registers at byte addresses 0, 4 and 8. The block takes one
// beat per clock while the queue is not full and returns one result beat per input beat, in
// order. A beat passes through seven front stages, one queue slot, one square root stage per
// result bit, one division stage per quotient bit and six stages for the roots and the axial
// clip. A four-entry queue separates the coefficient pipeline from the root pipeline, and an
// output stall holds the root pipeline and, once the queue fills, the input. Write the camera
// registers only while no beat is in flight.
module ray_finite_cylinder_intersect #(
	parameter int FRAC_BITS = rfci_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [31:0] dir_x,
	input wire logic signed [31:0] dir_y,
	input wire logic signed [31:0] dir_z,
	input wire logic signed [31:0] base_x,
	input wire logic signed [31:0] base_y,
	input wire logic signed [31:0] base_z,
	input wire logic signed [17:0] axis_x,
	input wire logic signed [17:0] axis_y,
	input wire logic signed [17:0] axis_z,
	input wire logic [30:0] radius,
	input wire logic [14:0] cyl_length,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] t_plus,
	output logic signed [31:0] t_minus,
	output logic plus_clipped,
	output logic minus_clipped,
	output logic [1:0] status
);

	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic front_en, push, pop, full, empty;
	rfci_pkg::geo_t geo_in;
	rfci_pkg::job_t job_w, job_r;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				rfci_pkg::REG_CAM_X: cam_x_q <= pwdata;
				rfci_pkg::REG_CAM_Y: cam_y_q <= pwdata;
				rfci_pkg::REG_CAM_Z: cam_z_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rfci_pkg::REG_CAM_X: prdata = cam_x_q;
			rfci_pkg::REG_CAM_Y: prdata = cam_y_q;
			rfci_pkg::REG_CAM_Z: prdata = cam_z_q;
			default: prdata = '0;
		endcase
	end

	always_comb begin
		geo_in.dx = dir_x;
		geo_in.dy = dir_y;
		geo_in.dz = dir_z;
		geo_in.bx = base_x;
		geo_in.by = base_y;
		geo_in.bz = base_z;
		geo_in.nx = axis_x;
		geo_in.ny = axis_y;
		geo_in.nz = axis_z;
		geo_in.len = cyl_length;
	end

	assign front_en = !full;
	assign in_ready = front_en;

	rfci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (front_en),
		.in_fire(in_valid && front_en),
		.geo_in (geo_in),
		.radius (radius),
		.cam_x  (cam_x_q),
		.cam_y  (cam_y_q),
		.cam_z  (cam_z_q),
		.push   (push),
		.job    (job_w)
	);

	rfci_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_w),
		.pop   (pop),
		.rdata (job_r),
		.full  (full),
		.empty (empty)
	);

	rfci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (!empty),
		.job          (job_r),
		.pop          (pop),
		.cam_x        (cam_x_q),
		.cam_y        (cam_y_q),
		.cam_z        (cam_z_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.t_plus       (t_plus),
		.t_minus      (t_minus),
		.plus_clipped (plus_clipped),
		.minus_clipped(minus_clipped),
		.status       (status)
	);

endmodule
`default_nettype wire
